@@ src/lk3_pkg.sv @@
// Shared types, constants and round functions for the lookup3 MAC hash.
`timescale 1ns / 1ps
package lk3_pkg;

  localparam logic [31:0] Golden    = 32'h9e37_79b9;
  localparam logic [31:0] KeyLen    = 32'd6;
  localparam logic [31:0] Extra     = 32'd3923095;
  localparam logic [31:0] InitWord  = Golden + KeyLen + Extra;
  localparam int          MixSteps  = 6;
  localparam int          FinSteps  = 7;

  typedef struct packed {
    logic        valid;
    logic        seeded;
    logic [31:0] key_a;
    logic [15:0] key_b;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } lk3_mix_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } lk3_fin_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned s);
    rotl32 = (x << s) | (x >> (32 - s));
  endfunction

  // x -= y; x ^= rotl(y, r)
  function automatic logic [31:0] mix_op(input logic [31:0] x, input logic [31:0] y,
                                         input int unsigned r);
    mix_op = (x - y) ^ rotl32(y, r);
  endfunction

  // x ^= y; x -= rotl(y, r)
  function automatic logic [31:0] fin_op(input logic [31:0] x, input logic [31:0] y,
                                         input int unsigned r);
    fin_op = (x ^ y) - rotl32(y, r);
  endfunction

  function automatic lk3_mix_t mix_step(input lk3_mix_t s, input int unsigned idx);
    lk3_mix_t r;
    r = s;
    case (idx)
      0: begin
        r.a = mix_op(s.a, s.c, 4);
        r.c = s.c + s.b;
      end
      1: begin
        r.b = mix_op(s.b, s.a, 6);
        r.a = s.a + s.c;
      end
      2: begin
        r.c = mix_op(s.c, s.b, 8);
        r.b = s.b + s.a;
      end
      3: begin
        r.a = mix_op(s.a, s.c, 16);
        r.c = s.c + s.b;
      end
      4: begin
        r.b = mix_op(s.b, s.a, 19);
        r.a = s.a + s.c;
      end
      5: begin
        r.c = mix_op(s.c, s.b, 4);
        r.b = s.b + s.a;
      end
      default: r = s;
    endcase
    return r;
  endfunction

  function automatic lk3_fin_t fin_step(input lk3_fin_t s, input int unsigned idx);
    lk3_fin_t r;
    r = s;
    case (idx)
      0: r.c = fin_op(s.c, s.b, 14);
      1: r.a = fin_op(s.a, s.c, 11);
      2: r.b = fin_op(s.b, s.a, 25);
      3: r.c = fin_op(s.c, s.b, 16);
      4: r.a = fin_op(s.a, s.c, 4);
      5: r.b = fin_op(s.b, s.a, 14);
      6: r.c = fin_op(s.c, s.b, 24);
      default: r = s;
    endcase
    return r;
  endfunction

endpackage

@@ src/mac_address_lookup3_hash.sv @@
// Top level of the pipelined lookup3 hash of a MAC address with a 64-bit seed.
//
// Usage:
//   Pulse start with mac_addr and hash_seed valid; the beat is taken at that
//   clock edge. busy is always low, so a new beat may be started every cycle.
//   Each beat yields one result: done is high for one cycle with hash_high
//   (word b) and hash_low (word c) on the result ports, in start order.
//   The beat passes one input register, six mix stages, one key-add stage
//   and seven final-round stages; done and the result ports come straight
//   from the last one. Throughput is one beat per cycle, set by the
//   fully pipelined add/xor/rotate stages.
//   A zero seed skips the seed mix: its stages still carry the beat, and the
//   key-add stage starts from the initial words instead.
//   Synchronous reset clears all stage valid bits; beats in flight are
//   dropped and no done pulse follows. The receiver cannot stall; results
//   must be taken in the cycle they appear.
`timescale 1ns / 1ps
module mac_address_lookup3_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [47:0] mac_addr,
  input  logic [63:0] hash_seed,
  output logic        done,
  output logic [31:0] hash_high,
  output logic [31:0] hash_low
);
  import lk3_pkg::*;

  lk3_mix_t in_reg;
  lk3_mix_t mix_out;
  lk3_fin_t key_reg;
  lk3_fin_t fin_out;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    in_reg.valid  <= start;
    in_reg.seeded <= (hash_seed != 64'd0);
    in_reg.key_a  <= {mac_addr[23:16], mac_addr[31:24], mac_addr[39:32], mac_addr[47:40]};
    in_reg.key_b  <= {mac_addr[7:0], mac_addr[15:8]};
    in_reg.a      <= InitWord + hash_seed[63:32];
    in_reg.b      <= InitWord + hash_seed[31:0];
    in_reg.c      <= InitWord;
    if (rst) begin
      in_reg.valid <= 1'b0;
    end
  end

  lk3_mix_pipe u_mix (
    .clk      (clk),
    .rst      (rst),
    .in_beat  (in_reg),
    .out_beat (mix_out)
  );

  always_ff @(posedge clk) begin
    key_reg.valid <= mix_out.valid;
    key_reg.a     <= (mix_out.seeded ? mix_out.a : InitWord) + mix_out.key_a;
    key_reg.b     <= (mix_out.seeded ? mix_out.b : InitWord) + {16'd0, mix_out.key_b};
    key_reg.c     <= mix_out.seeded ? mix_out.c : InitWord;
    if (rst) begin
      key_reg.valid <= 1'b0;
    end
  end

  lk3_final_pipe u_final (
    .clk      (clk),
    .rst      (rst),
    .in_beat  (key_reg),
    .out_beat (fin_out)
  );

  assign done      = fin_out.valid;
  assign hash_high = fin_out.b;
  assign hash_low  = fin_out.c;

endmodule

@@ src/lk3_mix_pipe.sv @@
// Seed mix round, one line of the round per register stage.
`timescale 1ns / 1ps
module lk3_mix_pipe (
  input  logic              clk,
  input  logic              rst,
  input  lk3_pkg::lk3_mix_t in_beat,
  output lk3_pkg::lk3_mix_t out_beat
);
  import lk3_pkg::*;

  lk3_mix_t stage [MixSteps];

  always_ff @(posedge clk) begin
    stage[0] <= mix_step(in_beat, 0);
    for (int i = 1; i < MixSteps; i++) begin
      stage[i] <= mix_step(stage[i-1], i);
    end
    if (rst) begin
      for (int i = 0; i < MixSteps; i++) begin
        stage[i].valid <= 1'b0;
      end
    end
  end

  assign out_beat = stage[MixSteps-1];

endmodule

@@ src/lk3_final_pipe.sv @@
// Final round, one line of the round per register stage.
`timescale 1ns / 1ps
module lk3_final_pipe (
  input  logic              clk,
  input  logic              rst,
  input  lk3_pkg::lk3_fin_t in_beat,
  output lk3_pkg::lk3_fin_t out_beat
);
  import lk3_pkg::*;

  lk3_fin_t stage [FinSteps];

  always_ff @(posedge clk) begin
    stage[0] <= fin_step(in_beat, 0);
    for (int i = 1; i < FinSteps; i++) begin
      stage[i] <= fin_step(stage[i-1], i);
    end
    if (rst) begin
      for (int i = 0; i < FinSteps; i++) begin
        stage[i].valid <= 1'b0;
      end
    end
  end

  assign out_beat = stage[FinSteps-1];

endmodule
